### hw/rtl/utf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf_pkg
// shared types and constants of the serial transmitter with byte queue
// ----------------------------------------------------------------------------
package utf_pkg;

	localparam int FIFO_DEPTH = 2048;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int LVL_W      = PTR_W + 1;
	localparam int DATA_BITS  = 8;
	localparam int TICK_W     = 16;
	localparam int POS_W      = 4;
	localparam int LEVEL_W    = 11;

	localparam logic [TICK_W-1:0] BIT_TICKS_RST = TICK_W'(26);
	localparam logic [POS_W-1:0]  POS_STOP      = POS_W'(DATA_BITS + 1);

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	typedef struct packed {
		logic                 cmd;
		logic [DATA_BITS-1:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic               line_level;
		logic               accepted;
		logic               dropped;
		logic [LEVEL_W-1:0] fifo_level;
		logic               busy_res;
	} out_item_t;

	typedef struct packed {
		op_t                  op;
		logic [DATA_BITS-1:0] data_byte;
	} job_t;

endpackage
`default_nettype wire

### hw/rtl/utf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module utf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

### hw/rtl/utf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf_front
// accepts input words, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module utf_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire utf_pkg::in_item_t din,
	output logic                   job_valid,
	output utf_pkg::job_t          job,
	input  wire logic              job_take
);
	import utf_pkg::*;

	job_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full      = (count_q == 2'd2);
	assign job_valid = (count_q != 2'd0);
	assign job       = slot_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = job_take && job_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q].op        <= op_t'(din.cmd);
			slot_q[wr_q].data_byte <= din.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("front queue count out of range");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> (wr_q == rd_q))
		else $error("front queue pointers disagree with count");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 && !push) |=> (count_q == 2'd0))
		else $error("front queue changed with no word pushed");

endmodule
`default_nettype wire

### hw/rtl/utf_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf_core
// byte queue pointers, frame timing and bit shifter; while the result queue has room, one word per cycle
// ----------------------------------------------------------------------------
module utf_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [utf_pkg::TICK_W-1:0]  cfg_data,
	input  wire logic                        job_valid,
	input  wire utf_pkg::job_t               job,
	output logic                             job_take,
	input  wire logic                        res_room,
	output logic                             res_valid,
	output utf_pkg::out_item_t               res
);
	import utf_pkg::*;

	logic [TICK_W-1:0]    bit_ticks_q;
	logic [PTR_W-1:0]     wp_q;
	logic [PTR_W-1:0]     rp_q;
	logic [DATA_BITS-1:0] shift_q;
	logic [POS_W-1:0]     pos_q;
	logic [TICK_W-1:0]    tick_q;
	logic                 sending_q;
	logic                 level_q;
	logic                 rd_pend_q;

	logic                 fire;
	logic [PTR_W-1:0]     wp_next;
	logic [PTR_W-1:0]     rp_next;
	logic                 not_empty;
	logic                 is_full;
	logic [TICK_W-1:0]    limit;
	logic [TICK_W:0]      tick_inc;
	logic [POS_W-1:0]     pos_inc;
	logic [DATA_BITS-1:0] shift_cur;
	logic [DATA_BITS-1:0] ram_rdata;
	logic                 ram_we;
	logic                 ram_re;

	logic [PTR_W-1:0]     wp_n;
	logic [PTR_W-1:0]     rp_n;
	logic [POS_W-1:0]     pos_n;
	logic [TICK_W-1:0]    tick_n;
	logic                 sending_n;
	logic                 level_n;
	logic                 acc_n;
	logic                 drop_n;
	logic [LVL_W-1:0]     lvl_n;

	assign fire      = job_valid && res_room;
	assign job_take  = fire;
	assign wp_next   = (wp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
	assign rp_next   = (rp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
	assign not_empty = (wp_q != rp_q);
	assign is_full   = (wp_next == rp_q);
	assign limit     = (bit_ticks_q == '0) ? TICK_W'(1) : bit_ticks_q;
	assign tick_inc  = {1'b0, tick_q} + (TICK_W+1)'(1);
	assign pos_inc   = pos_q + POS_W'(1);
	assign shift_cur = rd_pend_q ? ram_rdata : shift_q;

	always_comb begin
		wp_n      = wp_q;
		rp_n      = rp_q;
		pos_n     = pos_q;
		tick_n    = tick_q;
		sending_n = sending_q;
		level_n   = level_q;
		acc_n     = 1'b0;
		drop_n    = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		case (job.op)
			OP_WRITE: begin
				if (is_full) begin
					drop_n = 1'b1;
				end else begin
					ram_we = fire;
					wp_n   = wp_next;
					acc_n  = 1'b1;
				end
			end
			OP_TICK: begin
				if (!sending_q) begin
					if (not_empty) begin
						ram_re    = fire;
						rp_n      = rp_next;
						sending_n = 1'b1;
						pos_n     = '0;
						tick_n    = '0;
						level_n   = 1'b0;
					end
				end else if (tick_inc < {1'b0, limit}) begin
					tick_n = tick_inc[TICK_W-1:0];
				end else begin
					tick_n = '0;
					if (pos_inc <= POS_W'(DATA_BITS)) begin
						pos_n   = pos_inc;
						level_n = shift_cur[pos_q[2:0]];
					end else if (pos_inc == POS_STOP) begin
						pos_n   = pos_inc;
						level_n = 1'b1;
					end else begin
						sending_n = 1'b0;
						pos_n     = '0;
						level_n   = 1'b1;
						if (not_empty) begin
							ram_re    = fire;
							rp_n      = rp_next;
							sending_n = 1'b1;
							level_n   = 1'b0;
						end
					end
				end
			end
			default: begin
				drop_n = 1'b0;
			end
		endcase
		if (wp_n >= rp_n) begin
			lvl_n = {1'b0, wp_n} - {1'b0, rp_n};
		end else begin
			lvl_n = {1'b0, wp_n} + LVL_W'(FIFO_DEPTH) - {1'b0, rp_n};
		end
	end

	utf_ram #(
		.WIDTH (DATA_BITS),
		.DEPTH (FIFO_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (wp_q),
		.wr_data (job.data_byte),
		.rd_en   (ram_re),
		.rd_addr (rp_q),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_ticks_q <= BIT_TICKS_RST;
			wp_q        <= '0;
			rp_q        <= '0;
			shift_q     <= '0;
			pos_q       <= '0;
			tick_q      <= '0;
			sending_q   <= 1'b0;
			level_q     <= 1'b1;
			rd_pend_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				bit_ticks_q <= cfg_data;
			end
			shift_q   <= shift_cur;
			rd_pend_q <= ram_re;
			if (fire) begin
				wp_q      <= wp_n;
				rp_q      <= rp_n;
				pos_q     <= pos_n;
				tick_q    <= tick_n;
				sending_q <= sending_n;
				level_q   <= level_n;
			end
		end
	end

	assign res_valid       = fire;
	assign res.line_level  = level_n;
	assign res.accepted    = acc_n;
	assign res.dropped     = drop_n;
	assign res.fifo_level  = LEVEL_W'(lvl_n);
	assign res.busy_res    = sending_n;

	a_fetch_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> (sending_q && pos_q == '0 && !level_q))
		else $error("byte fetch not aligned with start bit");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!sending_q |-> (pos_q == '0 && tick_q == '0 && level_q))
		else $error("idle line with stale frame state");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_STOP)
		else $error("bit position past stop bit");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_re && ram_we))
		else $error("store read and written for one word");

endmodule
`default_nettype wire

### hw/rtl/utf_resq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf_resq
// two-entry result queue facing the receiver
// ----------------------------------------------------------------------------
module utf_resq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               res_valid,
	input  wire utf_pkg::out_item_t res,
	output logic                    res_room,
	output logic                    empty,
	input  wire logic               pop,
	output utf_pkg::out_item_t      dout
);
	import utf_pkg::*;

	out_item_t  slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	logic       do_pop;

	assign res_room = (count_q != 2'd2);
	assign empty    = (count_q == 2'd0);
	assign dout     = slot_q[rd_q];
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk) begin
		if (res_valid) begin
			slot_q[wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (res_valid) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			count_q <= count_q + {1'b0, res_valid} - {1'b0, do_pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_room)
		else $error("result written into full queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("result queue count out of range");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> (wr_q == rd_q))
		else $error("result queue pointers disagree with count");

endmodule
`default_nettype wire

### hw/rtl/uart_tx_with_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uart_tx_with_fifo
// 8N1 serial transmitter fed by a 2048-slot byte ring (2047 usable)
//
// input side is a queue: a word is taken when push is high and full is low;
// cmd 0 queues data_byte, cmd 1 is one timebase tick. every word gives exactly
// one result word: line level, accepted, dropped, bytes waiting and busy.
// result side is a queue too: the oldest result is on dout while empty is
// low and is taken when pop is high. each word is held in the front queue and
// its result in u_resq; one word per cycle is sustained while the receiver
// keeps popping, set by the single write / single read port of the byte
// store (a write and a frame start never meet in one word). bit_ticks is
// written through cfg_we / cfg_data; the user must write it only while the
// block is idle, which the block does not enforce; 0 acts as 1.
// reset empties both queues and the ring, sets bit_ticks to 26 and leaves
// the line high; no clearing pass is run. if the receiver stops popping,
// two results and two words are held, then full rises and input stalls.
// ----------------------------------------------------------------------------
module uart_tx_with_fifo (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	output logic                            full,
	input  wire utf_pkg::in_item_t          din,
	output logic                            empty,
	input  wire logic                       pop,
	output utf_pkg::out_item_t              dout,
	input  wire logic                       cfg_we,
	input  wire logic [utf_pkg::TICK_W-1:0] cfg_data
);
	import utf_pkg::*;

	logic      job_valid;
	job_t      job;
	logic      job_take;
	logic      res_room;
	logic      res_valid;
	out_item_t res;

	utf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.din       (din),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take)
	);

	utf_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take),
		.res_room  (res_room),
		.res_valid (res_valid),
		.res       (res)
	);

	utf_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_room  (res_room),
		.empty     (empty),
		.pop       (pop),
		.dout      (dout)
	);

endmodule
`default_nettype wire
